@@ src/kmp_pkg.sv @@
// Shared types and constants of the substring matcher.
package kmp_pkg;

  localparam int unsigned CmdWidth  = 2;
  localparam int unsigned ByteWidth = 8;

  typedef enum logic [CmdWidth-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEXT   = 2'd2,
    CMD_END    = 2'd3
  } cmd_e;

  // Broadcast from the control to every cell of the row.
  typedef struct packed {
    logic                 clear;
    logic                 append;
    logic                 text;
    logic                 rewind;
    logic [ByteWidth-1:0] byte_value;
  } cell_ctrl_t;

endpackage

@@ src/kmp_if.sv @@
// Valid/ready channels for command beats and result beats.
interface kmp_in_if;
  import kmp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CmdWidth-1:0]  cmd;
  logic [ByteWidth-1:0] byte_value;

  modport source (output valid, output cmd, output byte_value, input ready);
  modport sink (input valid, input cmd, input byte_value, output ready);
endinterface

interface kmp_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflow;

  modport source (output valid, output matched, output pattern_overflow, input ready);
  modport sink (input valid, input matched, input pattern_overflow, output ready);
endinterface

@@ src/kmp_cell.sv @@
// One matcher cell: a pattern byte, its loaded bit and its prefix match bit.
module kmp_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kmp_pkg::cell_ctrl_t ctrl_i,
  input  logic                left_valid_i,
  input  logic                left_match_i,
  input  logic                right_valid_i,
  output logic                valid_o,
  output logic                match_o,
  output logic                hit_o
);
  import kmp_pkg::*;

  logic                 valid_q, valid_d;
  logic                 match_q, match_d;
  logic [ByteWidth-1:0] byte_q, byte_d;
  logic                 step_match;

  // The prefix ending here extends the prefix that ended one byte earlier
  // in the left neighbor.
  assign step_match = left_match_i & valid_q & (byte_q == ctrl_i.byte_value);

  always_comb begin
    valid_d = valid_q;
    match_d = match_q;
    byte_d  = byte_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
      match_d = 1'b0;
    end else if (ctrl_i.rewind) begin
      match_d = 1'b0;
    end else if (ctrl_i.text) begin
      match_d = step_match;
    end else if (ctrl_i.append && left_valid_i && !valid_q) begin
      valid_d = 1'b1;
      byte_d  = ctrl_i.byte_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign valid_o = valid_q;
  assign match_o = match_q;
  // The last loaded cell matching means the whole pattern matched.
  assign hit_o   = ctrl_i.text & step_match & ~right_valid_i;

endmodule

@@ src/kmp_cell_row.sv @@
// Row of matcher cells, each linked to its neighbors.
module kmp_cell_row #(
  parameter int unsigned NumCells = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kmp_pkg::cell_ctrl_t ctrl_i,
  output logic                empty_o,
  output logic                full_o,
  output logic                hit_o
);
  import kmp_pkg::*;

  logic [NumCells:0]   valid_chain;
  logic [NumCells:0]   match_chain;
  logic [NumCells-1:0] hit;

  // Virtual cell in front of the row: always loaded, always matching.
  assign valid_chain[0] = 1'b1;
  assign match_chain[0] = 1'b1;

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    logic right_valid;
    if (i == NumCells - 1) begin : g_last
      assign right_valid = 1'b0;
    end else begin : g_mid
      assign right_valid = valid_chain[i+2];
    end

    kmp_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl_i),
      .left_valid_i  (valid_chain[i]),
      .left_match_i  (match_chain[i]),
      .right_valid_i (right_valid),
      .valid_o       (valid_chain[i+1]),
      .match_o       (match_chain[i+1]),
      .hit_o         (hit[i])
    );
  end

  assign empty_o = ~valid_chain[1];
  assign full_o  = valid_chain[NumCells];
  assign hit_o   = |hit;

endmodule

@@ src/kmp_substring_matcher.sv @@
// Top level of the streaming substring matcher.
// The pattern sits in a row of MAX_PATTERN cells, one byte per cell, and
// every text byte is compared in all cells at once while each cell's
// prefix-match bit moves one place to the right, so a text byte needs no
// walk along a failure chain. Only an end-of-text beat yields a result
// beat, registered in the cycle after it is accepted; a new beat is taken
// whenever that result register is empty or being emptied in the same
// cycle. Pattern bytes past MAX_PATTERN are dropped and flagged in
// pattern_overflow until the next clear.
module kmp_substring_matcher #(
  parameter int unsigned MAX_PATTERN = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kmp_in_if.sink    in_i,
  kmp_out_if.source out_o
);
  import kmp_pkg::*;

  logic       accept;
  cmd_e       cmd;
  cell_ctrl_t ctrl;
  logic       empty, full, hit;

  logic found_q, found_d;
  logic ovf_q, ovf_d;
  logic out_valid_q, out_valid_d;
  logic matched_q, matched_d;
  logic out_ovf_q, out_ovf_d;

  assign in_i.ready = ~out_valid_q | out_o.ready;
  assign accept     = in_i.valid & in_i.ready;
  assign cmd        = cmd_e'(in_i.cmd);

  always_comb begin
    ctrl            = '0;
    ctrl.byte_value = in_i.byte_value;
    found_d         = found_q;
    ovf_d           = ovf_q;
    out_valid_d     = out_valid_q & ~out_o.ready;
    matched_d       = matched_q;
    out_ovf_d       = out_ovf_q;
    if (accept) begin
      unique case (cmd)
        CMD_CLEAR: begin
          ctrl.clear = 1'b1;
          found_d    = 1'b0;
          ovf_d      = 1'b0;
        end
        CMD_APPEND: begin
          ctrl.append = ~full;
          if (full) begin
            ovf_d = 1'b1;
          end
        end
        CMD_TEXT: begin
          // Text after a full match, or against an empty pattern, is ignored.
          ctrl.text = ~found_q & ~empty;
          if (ctrl.text && hit) begin
            found_d = 1'b1;
          end
        end
        CMD_END: begin
          ctrl.rewind = 1'b1;
          found_d     = 1'b0;
          out_valid_d = 1'b1;
          matched_d   = found_q | empty;
          out_ovf_d   = ovf_q;
        end
        default: begin
        end
      endcase
    end
  end

  kmp_cell_row #(
    .NumCells (MAX_PATTERN)
  ) u_row (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .empty_o (empty),
    .full_o  (full),
    .hit_o   (hit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q     <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      found_q     <= found_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    matched_q <= matched_d;
    out_ovf_q <= out_ovf_d;
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.matched          = matched_q;
  assign out_o.pattern_overflow = out_ovf_q;

endmodule

@@ src/kmp_checker.sv @@
// Port-level checks of the substring matcher, bound to its top level.
module kmp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic [kmp_pkg::CmdWidth-1:0] in_cmd_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic                         out_matched_i,
  input logic                         out_overflow_i
);
  import kmp_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i & in_ready_i;

  // A stalled result blocks new command beats.
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("command beat taken while a result is stalled");

  // Every end-of-text beat produces a result beat in the next cycle.
  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_cmd_i == CMD_END) |=> out_valid_i)
    else $error("end of text produced no result");

  // Without an end-of-text beat a fresh result cannot appear.
  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_acc && (in_cmd_i == CMD_END)) |=> !out_valid_i || $past(out_valid_i && !out_ready_i))
    else $error("result beat without end of text");

  // An empty pattern always matches and has dropped nothing.
  a_empty_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_cmd_i == CMD_CLEAR)) ##1 (in_acc && (in_cmd_i == CMD_END))
      |=> out_matched_i && !out_overflow_i)
    else $error("empty pattern did not report a clean match");

  // A stalled result holds its payload.
  a_result_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_matched_i) && $stable(out_overflow_i))
    else $error("stalled result changed");

endmodule

bind kmp_substring_matcher kmp_checker u_kmp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_cmd_i       (in_i.cmd),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_matched_i  (out_o.matched),
  .out_overflow_i (out_o.pattern_overflow)
);

@@ sim/kmp_substring_matcher_tb.sv @@
// Self-checking testbench of the substring matcher: command beats in, match verdicts checked.
`timescale 1ns / 100ps

module kmp_substring_matcher_tb;
  import kmp_pkg::*;

  localparam int unsigned MaxPattern  = 32;
  localparam int unsigned ClkPeriod   = 8;
  localparam int unsigned TargetBeats = 850;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned HoldCycles  = 150;
  localparam int unsigned DrainCycles = 10;

  typedef struct {
    logic matched;
    logic pattern_overflow;
  } verdict_t;

  // Tracks the search state of the block and the verdicts still owed by it.
  class match_scoreboard;
    logic [ByteWidth-1:0] pat_bytes [MaxPattern];
    int                   fail_link [MaxPattern+1];
    int                   pat_len;
    int                   build_pos;
    int                   scan_pos;
    logic                 found;
    logic                 overflowed;
    verdict_t             verdicts [$];
    int                   errors;

    function new();
      foreach (pat_bytes[i]) pat_bytes[i] = '0;
      foreach (fail_link[i]) fail_link[i] = 0;
      errors = 0;
      wipe_pattern();
    endfunction

    function void wipe_pattern();
      fail_link[0] = -1;
      pat_len      = 0;
      build_pos    = -1;
      scan_pos     = 0;
      found        = 1'b0;
      overflowed   = 1'b0;
    endfunction

    // Extends the partial-match table by one pattern byte.
    function void add_pattern_byte(logic [ByteWidth-1:0] b);
      int k;
      if (pat_len >= MaxPattern) begin
        overflowed = 1'b1;
        return;
      end
      k = build_pos;
      while (k >= 0 && k < pat_len && pat_bytes[k] != b) k = fail_link[k];
      if (k >= pat_len) k = -1;
      pat_bytes[pat_len] = b;
      pat_len++;
      build_pos = k + 1;
      fail_link[pat_len] = build_pos;
    endfunction

    function void scan_text_byte(logic [ByteWidth-1:0] b);
      int k;
      if (pat_len == 0 || found) return;
      k = scan_pos;
      if (k < 0 || k >= pat_len) k = 0;
      while (k >= 0 && pat_bytes[k] != b) k = fail_link[k];
      k++;
      if (k >= pat_len) begin
        found = 1'b1;
        k = 0;
      end
      scan_pos = k;
    endfunction

    function void note_command(cmd_e c, logic [ByteWidth-1:0] b);
      verdict_t v;
      case (c)
        CMD_CLEAR:  wipe_pattern();
        CMD_APPEND: add_pattern_byte(b);
        CMD_TEXT:   scan_text_byte(b);
        default: begin
          v.matched          = found || (pat_len == 0);
          v.pattern_overflow = overflowed;
          verdicts.push_back(v);
          scan_pos = 0;
          found    = 1'b0;
        end
      endcase
    endfunction

    task report(string what);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    task check_verdict(logic matched, logic pattern_overflow);
      verdict_t v;
      if (verdicts.size() == 0) begin
        report("result beat arrived with no verdict pending");
        return;
      end
      v = verdicts.pop_front();
      if (matched !== v.matched)
        report($sformatf("matched is %b, expected %b", matched, v.matched));
      if (pattern_overflow !== v.pattern_overflow)
        report($sformatf("pattern_overflow is %b, expected %b",
                         pattern_overflow, v.pattern_overflow));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  kmp_in_if  in_if ();
  kmp_out_if out_if ();

  kmp_substring_matcher #(
    .MAX_PATTERN(MaxPattern)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  match_scoreboard board = new();

  logic                 gaps_on;
  logic                 hold_request;
  int                   beats_sent;
  int                   quiet_cycles;
  logic                 in_hit;
  logic                 out_hit;
  logic [ByteWidth-1:0] alpha [3];
  logic [ByteWidth-1:0] cur_pattern [$];

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Both channels are sampled here, at the rising edge, before any register moves.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_hit  = in_if.valid && in_if.ready;
      out_hit = out_if.valid && out_if.ready;
      if (in_hit) board.note_command(cmd_e'(in_if.cmd), in_if.byte_value);
      if (out_hit) board.check_verdict(out_if.matched, out_if.pattern_overflow);
      if (in_hit || out_hit) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        out_if.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_request = 1'b0;
      end else begin
        out_if.ready = gaps_on ? ($urandom_range(99) >= 32) : 1'b1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(cmd_e c, logic [ByteWidth-1:0] b);
    if (gaps_on) begin
      while ($urandom_range(99) < 32) begin
        in_if.valid = 1'b0;
        @(negedge clk_i);
      end
    end
    in_if.valid      = 1'b1;
    in_if.cmd        = c;
    in_if.byte_value = b;
    do @(posedge clk_i); while (!in_if.ready);
    beats_sent++;
    @(negedge clk_i);
  endtask

  // One text over the current alphabet, with the pattern planted now and then.
  task automatic random_text(int len);
    logic [ByteWidth-1:0] b;
    for (int i = 0; i < len; i++) begin
      if (cur_pattern.size() > 0 && $urandom_range(7) == 0) begin
        foreach (cur_pattern[j]) send_beat(CMD_TEXT, cur_pattern[j]);
      end else if ($urandom_range(39) == 0) begin
        // A pattern byte in the middle of a text keeps the matched prefix valid.
        b = alpha[$urandom_range(2)];
        send_beat(CMD_APPEND, b);
        if (cur_pattern.size() < MaxPattern) cur_pattern.push_back(b);
      end else begin
        send_beat(CMD_TEXT, alpha[$urandom_range(2)]);
      end
    end
    send_beat(CMD_END, 8'($urandom_range(255)));
  endtask

  task automatic search_round();
    int                   len;
    logic [ByteWidth-1:0] b;
    send_beat(CMD_CLEAR, 8'($urandom_range(255)));
    foreach (alpha[i]) alpha[i] = 8'($urandom_range(255));
    if ($urandom_range(19) == 0) len = 0;
    else if ($urandom_range(11) == 0) len = $urandom_range(MaxPattern - 3, MaxPattern + 2);
    else len = $urandom_range(1, 6);
    cur_pattern.delete();
    for (int i = 0; i < len; i++) begin
      b = alpha[$urandom_range(2)];
      send_beat(CMD_APPEND, b);
      if (cur_pattern.size() < MaxPattern) cur_pattern.push_back(b);
    end
    repeat ($urandom_range(1, 3)) random_text($urandom_range(0, 16));
  endtask

  initial begin
    int round;
    int pick;
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.cmd        = CMD_CLEAR;
    in_if.byte_value = '0;
    gaps_on          = 1'b1;
    hold_request     = 1'b0;
    beats_sent       = 0;
    quiet_cycles     = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty pattern, byte extremes, fallback, text after a match,
    // and a pattern byte appended in the middle of a text.
    send_beat(CMD_END, 8'hFF);
    send_beat(CMD_TEXT, 8'h00);
    send_beat(CMD_END, 8'h00);
    send_beat(CMD_CLEAR, 8'hA5);
    send_beat(CMD_APPEND, 8'h00);
    send_beat(CMD_APPEND, 8'hFF);
    send_beat(CMD_APPEND, 8'h00);
    send_beat(CMD_TEXT, 8'h00);
    send_beat(CMD_TEXT, 8'h00);
    send_beat(CMD_TEXT, 8'hFF);
    send_beat(CMD_TEXT, 8'h00);
    send_beat(CMD_TEXT, 8'h55);
    send_beat(CMD_END, 8'h5A);
    send_beat(CMD_TEXT, 8'hFF);
    send_beat(CMD_TEXT, 8'h00);
    send_beat(CMD_END, 8'h00);
    send_beat(CMD_TEXT, 8'h00);
    send_beat(CMD_TEXT, 8'hFF);
    send_beat(CMD_APPEND, 8'h7F);
    send_beat(CMD_TEXT, 8'h00);
    send_beat(CMD_TEXT, 8'h7F);
    send_beat(CMD_END, 8'hFF);
    send_beat(CMD_TEXT, 8'h00);
    send_beat(CMD_END, 8'h00);

    round = 0;
    while (beats_sent < TargetBeats) begin
      gaps_on = !(round >= 12 && round < 24);
      if (round == 6) hold_request = 1'b1;
      pick = $urandom_range(99);
      if (pick < 70) begin
        search_round();
      end else if (pick < 85) begin
        random_text($urandom_range(0, 16));
      end else begin
        repeat ($urandom_range(1, 4))
          send_beat(cmd_e'(2'($urandom_range(3))), 8'($urandom_range(255)));
      end
      round++;
    end
    in_if.valid = 1'b0;

    while (board.verdicts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.verdicts.size() != 0)
      board.report($sformatf("%0d verdicts never arrived", board.verdicts.size()));
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ kmp_substring_matcher.f @@
src/kmp_pkg.sv
src/kmp_if.sv
src/kmp_cell.sv
src/kmp_cell_row.sv
src/kmp_substring_matcher.sv
src/kmp_checker.sv
sim/kmp_substring_matcher_tb.sv
